// File: rtl/rmru_pkg.sv
// Shared types and constants for the recent address list.
package rmru_pkg;

    localparam int MODE_W = 2;
    localparam int ADDR_W = 64;
    localparam int PORT_W = 16;
    localparam int RES_W  = 4;

    localparam logic [MODE_W-1:0] MODE_RECORD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FETCH  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REWIND = 2'd2;

    localparam int S_TDATA_W = 152;
    localparam int M_TDATA_W = 160;

    // Bit positions of result fields on the master-side tdata.
    localparam int M_FOUND_BIT = 0;
    localparam int M_POS_LSB   = 1;
    localparam int M_VALID_BIT = 5;

    typedef struct packed {
        logic              family;
        logic [ADDR_W-1:0] addr_high;
        logic [ADDR_W-1:0] addr_low;
        logic [PORT_W-1:0] port;
    } entry_t;

    // Token handed from one cell to the next during a scan.
    typedef struct packed {
        logic   found;
        entry_t data;
    } scan_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

// File: rtl/rmru_cell.sv
// One list cell: holds an entry and passes the scan token to its neighbour.
module rmru_cell #(
    parameter int IDX        = 0,
    parameter int IW         = 3,
    parameter int CW         = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  rmru_pkg::entry_t key,
    input  logic [CW-1:0]    count,
    input  logic [CW-1:0]    ptr,
    input  logic [IW-1:0]    slot,
    input  logic             move,
    input  rmru_pkg::entry_t entry_in,
    output rmru_pkg::entry_t entry_out,
    input  rmru_pkg::scan_t  scan_in,
    input  logic [IW-1:0]    pos_in,
    output rmru_pkg::scan_t  scan_out,
    output logic [IW-1:0]    pos_out
);

    localparam logic [CW-1:0] IDX_C = CW'(IDX);
    localparam logic [IW-1:0] IDX_I = IW'(IDX);

    rmru_pkg::entry_t entry_reg;
    logic             found_reg;
    rmru_pkg::entry_t data_reg;
    rmru_pkg::scan_t  scan_next;
    logic [IW-1:0]    pos_reg;
    logic [IW-1:0]    pos_next;
    logic             match;

    assign match = (IDX_C < count) && (entry_reg == key);

    always_comb
    begin
        scan_next = scan_in;
        pos_next  = pos_in;
        if (!scan_in.found && match)
        begin
            scan_next.found = 1'b1;
            pos_next        = IDX_I;
        end
        if (ptr == IDX_C)
        begin
            scan_next.data = entry_reg;
        end
    end

    // Cells up to the target slot shift down a place; cell zero takes the request.
    always_ff @(posedge clk)
    begin
        if (move && (IDX_I <= slot))
        begin
            entry_reg <= entry_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= scan_next.found;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= scan_next.data;
        pos_reg  <= pos_next;
    end

    assign entry_out = entry_reg;
    assign scan_out  = {found_reg, data_reg};
    assign pos_out   = pos_reg;

endmodule

// File: rtl/recent_address_mru_list.sv
// Top level of the most-recently-used address list.
//
//  Channel  Direction  Handshake            Content
//  s_*      in         s_tvalid / s_tready  tuser: mode; tdata: family, address, port
//  m_*      out        m_tvalid / m_tready  tdata: record, fetch and count results
//
// Each transfer captures the request, lets the scan token ripple down the chain of
// cells and then commits the result. The chain length sets the length of the scan.
// Reset clears the entry count, the fetch pointer and all handshake state; the stored
// entries are left as they are and are only read once they have been written.
// A new request is taken once the previous one has committed, even while its result
// still waits in the output register; a stalled master side holds the commit step.
module recent_address_mru_list #(
    parameter int LIST_DEPTH = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [0] family, [64:1] addr_high, [128:65] addr_low, [144:129] port, rest zero
    input  logic [151:0] s_tdata,
    // [1:0] mode
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [0] found, [4:1] position, [5] valid_res, [6] out_family,
    // [70:7] out_addr_high, [134:71] out_addr_low, [150:135] out_port,
    // [154:151] used_count, rest zero
    output logic [159:0] m_tdata
);

    localparam int IW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C   = CW'(LIST_DEPTH);
    localparam logic [IW-1:0] LAST_STEP = IW'(LIST_DEPTH - 1);

    rmru_pkg::state_t state_reg;
    rmru_pkg::state_t state_next;

    rmru_pkg::entry_t             key_reg;
    logic [rmru_pkg::MODE_W-1:0]  mode_reg;
    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                count_next;
    logic [CW-1:0]                ptr_reg;
    logic [CW-1:0]                ptr_next;
    logic [IW-1:0]                step_reg;

    logic                         m_tvalid_reg;
    logic [rmru_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [rmru_pkg::M_TDATA_W-1:0] m_tdata_next;

    logic accept;
    logic commit;

    // Chain wiring: scan and pos element k feed cell k, element k+1 is its output.
    rmru_pkg::entry_t entry_chain [LIST_DEPTH];
    rmru_pkg::entry_t cell_entry  [LIST_DEPTH];
    rmru_pkg::scan_t  scan_chain  [LIST_DEPTH+1];
    logic [IW-1:0]    pos_chain   [LIST_DEPTH+1];

    logic          hit;
    logic [IW-1:0] hit_pos;
    logic [CW-1:0] count_inc;
    logic [IW-1:0] slot;
    logic          move;

    // Result fields
    logic                        found;
    logic [rmru_pkg::RES_W-1:0]  position;
    logic                        valid_res;
    rmru_pkg::entry_t            fetched;

    assign accept = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Chain of cells. Cell zero is fed with the request itself, so a move
    // writes the new entry at the front while the cells up to the slot shift down.
    // ------------------------------------------------------------------
    assign scan_chain[0] = '0;
    assign pos_chain[0]  = '0;

    for (genvar k = 0; k < LIST_DEPTH; k++)
    begin : g_cell
        if (k == 0)
        begin : g_front
            assign entry_chain[k] = key_reg;
        end
        else
        begin : g_rest
            assign entry_chain[k] = cell_entry[k-1];
        end

        rmru_cell #(
            .IDX        (k),
            .IW         (IW),
            .CW         (CW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .key       (key_reg),
            .count     (count_reg),
            .ptr       (ptr_reg),
            .slot      (slot),
            .move      (move),
            .entry_in  (entry_chain[k]),
            .entry_out (cell_entry[k]),
            .scan_in   (scan_chain[k]),
            .pos_in    (pos_chain[k]),
            .scan_out  (scan_chain[k+1]),
            .pos_out   (pos_chain[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rmru_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = rmru_pkg::ST_SCAN;
                end
            end
            rmru_pkg::ST_SCAN:
            begin
                if (step_reg == LAST_STEP)
                begin
                    state_next = rmru_pkg::ST_DONE;
                end
            end
            rmru_pkg::ST_DONE:
            begin
                if (commit)
                begin
                    state_next = rmru_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rmru_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = (state_reg == rmru_pkg::ST_IDLE);
        commit   = (state_reg == rmru_pkg::ST_DONE) && (!m_tvalid_reg || m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rmru_pkg::ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                step_reg <= '0;
            end
            else if (state_reg == rmru_pkg::ST_SCAN)
            begin
                step_reg <= step_reg + IW'(1);
            end
        end
    end

    // Request capture; held steady for the whole scan.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg.family    <= s_tdata[0];
            key_reg.addr_high <= s_tdata[64:1];
            key_reg.addr_low  <= s_tdata[128:65];
            key_reg.port      <= s_tdata[144:129];
            mode_reg          <= s_tuser;
        end
    end

    // ------------------------------------------------------------------
    // Commit: the last cell now carries the first hit and the entry at the
    // fetch pointer.
    // ------------------------------------------------------------------
    assign hit       = scan_chain[LIST_DEPTH].found;
    assign hit_pos   = pos_chain[LIST_DEPTH];
    assign fetched   = scan_chain[LIST_DEPTH].data;
    assign count_inc = (count_reg < DEPTH_C) ? (count_reg + CW'(1)) : count_reg;
    assign slot      = hit ? hit_pos : IW'(count_inc - CW'(1));

    // A hit at the front leaves the list as it is.
    assign move = commit && (mode_reg == rmru_pkg::MODE_RECORD)
                  && (!hit || (hit_pos != '0));

    always_comb
    begin
        count_next = count_reg;
        ptr_next   = ptr_reg;
        found      = 1'b0;
        position   = '0;
        valid_res  = 1'b0;
        unique case (mode_reg)
            rmru_pkg::MODE_RECORD:
            begin
                found    = hit;
                position = hit ? rmru_pkg::RES_W'(hit_pos)
                               : rmru_pkg::RES_W'(LIST_DEPTH);
                if (!hit)
                begin
                    count_next = count_inc;
                end
            end
            rmru_pkg::MODE_FETCH:
            begin
                if (ptr_reg < count_reg)
                begin
                    valid_res = 1'b1;
                    ptr_next  = ptr_reg + CW'(1);
                end
            end
            rmru_pkg::MODE_REWIND:
            begin
                ptr_next = '0;
            end
            default:
            begin
                // Unused code: state untouched, only the count is reported.
            end
        endcase
    end

    always_comb
    begin
        m_tdata_next = {5'b0,
                        rmru_pkg::RES_W'(count_next),
                        valid_res ? fetched.port      : {rmru_pkg::PORT_W{1'b0}},
                        valid_res ? fetched.addr_low  : {rmru_pkg::ADDR_W{1'b0}},
                        valid_res ? fetched.addr_high : {rmru_pkg::ADDR_W{1'b0}},
                        valid_res && fetched.family,
                        valid_res,
                        position,
                        found};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            ptr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (commit)
            begin
                count_reg    <= count_next;
                ptr_reg      <= ptr_next;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: rtl/rmru_checker.sv
// Port-level checks for the recent address list, bound to the top level.
module rmru_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [159:0] m_tdata
);

    localparam int FB = rmru_pkg::M_FOUND_BIT;
    localparam int PB = rmru_pkg::M_POS_LSB;
    localparam int VB = rmru_pkg::M_VALID_BIT;

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Only one request is worked on at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken during a scan");

    // A result is never both a record hit and a fetch result.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[FB] && m_tdata[VB]))
        else $error("found and valid_res both set");

    a_fetch_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[VB] |-> m_tdata[PB+3:PB] == 4'd0)
        else $error("fetch result carries a position");

endmodule

bind recent_address_mru_list rmru_checker u_rmru_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
